// ----- rtl/core/tgem_pkg.sv -----
// Shared types, constants and helpers for the threshold gradient edge map.
// Used by the queue cell, the line buffer and the top level.
package tgem_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int PIX_W       = 8;
    localparam int SIZE_W      = 11;
    localparam int OUT_W       = 10;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int QUEUE_DEPTH = 4;
    localparam int SLOT_N      = 3;
    localparam int SLOT_W      = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

    typedef struct packed {
        logic             edge_bit;
        logic [OUT_W-1:0] out_row;
        logic [OUT_W-1:0] out_col;
        logic             frame_done;
    } t_result;

    // All results released by one pixel, oldest in slot 0.
    typedef struct packed {
        logic [SLOT_W-1:0]        count;
        t_result [SLOT_N-1:0]     slot;
    } t_record;

    typedef struct packed {
        logic pop;
        logic push;
    } t_cell_ctl;

    function automatic logic exceeds(input logic [PIX_W-1:0] a,
                                     input logic [PIX_W-1:0] b,
                                     input logic [PIX_W-1:0] thr);
        logic [PIX_W-1:0] diff;
        diff = (a > b) ? (a - b) : (b - a);
        return diff > thr;
    endfunction

endpackage

// ----- rtl/core/tgem_cell.sv -----
// One cell of the output record queue: holds one record and shifts it toward
// the head on a pop. Depends on tgem_pkg.
module tgem_cell import tgem_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  logic      i_up_valid,
    input  t_record   i_up_data,
    input  t_record   i_push_data,
    input  logic      i_down_pvalid,
    output logic      o_valid,
    output t_record   o_data,
    output logic      o_pvalid
);

    logic    r_valid;
    logic    n_valid;
    t_record r_data;
    t_record n_data;
    logic    w_load_push;

    always_comb begin
        // occupancy once the pop has moved everything one step forward
        o_pvalid    = i_ctl.pop ? i_up_valid : r_valid;
        // take the new record if this is the first free cell after the shift
        w_load_push = i_ctl.push && !o_pvalid && i_down_pvalid;
        n_valid     = o_pvalid || w_load_push;
        n_data      = r_data;
        if (i_ctl.pop) begin
            n_data = i_up_data;
        end
        if (w_load_push) begin
            n_data = i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- rtl/core/tgem_line_buf.sv -----
// One-row line buffer: single write port, registered read with write bypass.
// Depends on tgem_pkg.
module tgem_line_buf import tgem_pkg::*; (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [COL_W-1:0] i_waddr,
    input  logic [PIX_W-1:0] i_wdata,
    input  logic             i_re,
    input  logic [COL_W-1:0] i_raddr,
    output logic [PIX_W-1:0] o_rdata
);

    logic [PIX_W-1:0] r_mem [MAX_WIDTH];
    logic [PIX_W-1:0] r_rd;
    logic [PIX_W-1:0] r_wq;
    logic             r_byp;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd  <= r_mem[i_raddr];
            r_byp <= i_we && (i_waddr == i_raddr);
            r_wq  <= i_wdata;
        end
    end

    assign o_rdata = r_byp ? r_wq : r_rd;

endmodule

// ----- rtl/core/threshold_gradient_edge_map.sv -----
// Threshold gradient edge map: one pixel per cycle in and one result per cycle out
// when neither side stalls. A pixel's result leaves once the pixel below it has been
// accepted and its record has passed the result stage and the queue; last-row pixels
// release up to three results each, so that row drains through a 4-record queue of
// shifting cells.
// Reset (synchronous, active low) clears counters, queue and registers
// (threshold 0, size 1024x1024); the line buffer is not cleared.
module threshold_gradient_edge_map import tgem_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [PIX_W-1:0]      i_pixel_value,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_edge_bit,
    output logic [OUT_W-1:0]      o_out_row,
    output logic [OUT_W-1:0]      o_out_col,
    output logic                  o_last_in_run,
    output logic                  o_frame_done
);

    // configuration
    logic [PIX_W-1:0]  r_threshold;
    logic [SIZE_W-1:0] r_frame_width;
    logic [SIZE_W-1:0] r_frame_height;

    // position and left neighbor
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [PIX_W-1:0]  r_left;

    logic [COL_W:0]    w_w_eff;
    logic [ROW_W:0]    w_h_eff;
    logic              w_last_col;
    logic              w_last_row;
    logic [COL_W-1:0]  w_col_next;
    logic              w_in_acc;
    logic [PIX_W-1:0]  w_line_q;

    // result stage
    logic              r_s1_valid;
    logic [PIX_W-1:0]  r_s1_pix;
    logic [PIX_W-1:0]  r_s1_above;
    logic [PIX_W-1:0]  r_s1_left;
    logic [ROW_W-1:0]  r_s1_row;
    logic [COL_W-1:0]  r_s1_col;
    logic              r_s1_has_up;
    logic              r_s1_has_left;
    logic              r_s1_last_row;
    logic              r_s1_last_col;
    t_record           w_rec;
    t_result           w_res_up;
    t_result           w_res_left;
    t_result           w_res_self;
    logic [SLOT_W-1:0] w_k;

    // output queue
    logic [QUEUE_DEPTH-1:0] w_valid;
    logic [QUEUE_DEPTH-1:0] w_pvalid;
    t_record                w_data [QUEUE_DEPTH];
    t_cell_ctl              w_ctl;
    t_record                w_head;
    t_result                w_head_res;
    logic [SLOT_W-1:0]      r_idx;
    logic                   w_out_xfer;
    logic                   w_head_last;

    // ---------------- configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold    <= '0;
            r_frame_width  <= SIZE_W'(1024);
            r_frame_height <= SIZE_W'(1024);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD:    r_threshold    <= PIX_W'(i_cfg_data);
                CFG_FRAME_WIDTH:  r_frame_width  <= SIZE_W'(i_cfg_data);
                CFG_FRAME_HEIGHT: r_frame_height <= SIZE_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // zero acts as one, oversize saturates
    always_comb begin
        if (r_frame_width == '0) begin
            w_w_eff = (COL_W+1)'(1);
        end else if (int'(r_frame_width) > MAX_WIDTH) begin
            w_w_eff = (COL_W+1)'(MAX_WIDTH);
        end else begin
            w_w_eff = (COL_W+1)'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            w_h_eff = (ROW_W+1)'(1);
        end else if (int'(r_frame_height) > MAX_HEIGHT) begin
            w_h_eff = (ROW_W+1)'(MAX_HEIGHT);
        end else begin
            w_h_eff = (ROW_W+1)'(r_frame_height);
        end
    end

    // ---------------- input side
    assign w_in_acc   = i_valid && !o_stall;
    assign w_last_col = ({1'b0, r_col} + (COL_W+1)'(1)) >= w_w_eff;
    assign w_last_row = ({1'b0, r_row} + (ROW_W+1)'(1)) >= w_h_eff;
    assign w_col_next = w_last_col ? '0 : r_col + COL_W'(1);

    // reserve room for the record in flight and the one being accepted
    assign o_stall = (int'($countones(w_valid)) + int'(r_s1_valid)) >= QUEUE_DEPTH;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_left <= '0;
        end else if (w_in_acc) begin
            r_col  <= w_col_next;
            r_left <= i_pixel_value;
            if (w_last_col) begin
                r_row <= w_last_row ? '0 : r_row + ROW_W'(1);
            end
        end
    end

    // write this column, prefetch the next one: it is the right-above
    // neighbor now and the above neighbor for the next transfer
    tgem_line_buf u_line_buf (
        .i_clk   (i_clk),
        .i_we    (w_in_acc),
        .i_waddr (r_col),
        .i_wdata (i_pixel_value),
        .i_re    (w_in_acc),
        .i_raddr (w_col_next),
        .o_rdata (w_line_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_pix      <= i_pixel_value;
            r_s1_above    <= w_line_q;
            r_s1_left     <= r_left;
            r_s1_row      <= r_row;
            r_s1_col      <= r_col;
            r_s1_has_up   <= (r_row != '0);
            r_s1_has_left <= (r_col != '0);
            r_s1_last_row <= w_last_row;
            r_s1_last_col <= w_last_col;
        end
    end

    // ---------------- result stage
    always_comb begin
        w_res_up.edge_bit   = !(exceeds(r_s1_above, r_s1_pix, r_threshold) ||
                                (!r_s1_last_col &&
                                 exceeds(r_s1_above, w_line_q, r_threshold)));
        w_res_up.out_row    = OUT_W'(r_s1_row - ROW_W'(1));
        w_res_up.out_col    = OUT_W'(r_s1_col);
        w_res_up.frame_done = 1'b0;

        w_res_left.edge_bit   = !exceeds(r_s1_left, r_s1_pix, r_threshold);
        w_res_left.out_row    = OUT_W'(r_s1_row);
        w_res_left.out_col    = OUT_W'(r_s1_col - COL_W'(1));
        w_res_left.frame_done = 1'b0;

        // final pixel has no neighbors: always flat
        w_res_self.edge_bit   = 1'b1;
        w_res_self.out_row    = OUT_W'(r_s1_row);
        w_res_self.out_col    = OUT_W'(r_s1_col);
        w_res_self.frame_done = 1'b1;

        w_rec = '0;
        w_k   = '0;
        if (r_s1_has_up) begin
            w_rec.slot[w_k] = w_res_up;
            w_k = w_k + SLOT_W'(1);
        end
        if (r_s1_last_row && r_s1_has_left) begin
            w_rec.slot[w_k] = w_res_left;
            w_k = w_k + SLOT_W'(1);
        end
        if (r_s1_last_row && r_s1_last_col) begin
            w_rec.slot[w_k] = w_res_self;
            w_k = w_k + SLOT_W'(1);
        end
        w_rec.count = w_k;
    end

    // ---------------- output queue
    assign w_head      = w_data[0];
    assign w_head_res  = w_head.slot[r_idx];
    assign w_head_last = (r_idx == (w_head.count - SLOT_W'(1)));
    assign w_out_xfer  = o_valid && !i_stall;
    assign w_ctl.pop   = w_out_xfer && w_head_last;
    assign w_ctl.push  = r_s1_valid && (w_rec.count != '0);

    for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
        logic    w_up_valid;
        t_record w_up_data;
        logic    w_down_pvalid;

        if (gi == QUEUE_DEPTH - 1) begin : g_tail
            assign w_up_valid = 1'b0;
            assign w_up_data  = w_rec;
        end else begin : g_mid
            assign w_up_valid = w_valid[gi+1];
            assign w_up_data  = w_data[gi+1];
        end

        if (gi == 0) begin : g_head
            assign w_down_pvalid = 1'b1;
        end else begin : g_rest
            assign w_down_pvalid = w_pvalid[gi-1];
        end

        tgem_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_up_valid    (w_up_valid),
            .i_up_data     (w_up_data),
            .i_push_data   (w_rec),
            .i_down_pvalid (w_down_pvalid),
            .o_valid       (w_valid[gi]),
            .o_data        (w_data[gi]),
            .o_pvalid      (w_pvalid[gi])
        );
    end

    // step through the head record one result per transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (w_out_xfer) begin
            r_idx <= w_head_last ? '0 : r_idx + SLOT_W'(1);
        end
    end

    assign o_valid       = w_valid[0];
    assign o_edge_bit    = w_head_res.edge_bit;
    assign o_out_row     = w_head_res.out_row;
    assign o_out_col     = w_head_res.out_col;
    assign o_frame_done  = w_head_res.frame_done;
    assign o_last_in_run = w_head_last;

    // ---------------- checks
    a_push_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.push |-> (w_ctl.pop || !w_valid[QUEUE_DEPTH-1]))
        else $error("record pushed into a full queue");

    a_cells_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid >> 1) & ~w_valid) == '0)
        else $error("hole in the output queue");

    a_idx_in_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_idx < w_head.count))
        else $error("result index past the head record");

    a_done_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_done) |-> o_last_in_run)
        else $error("frame end is not the last result of its pixel");

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

// ----- bench/tgem_checker.sv -----
// Scoreboard for the threshold gradient edge map: watches register writes and both
// channels, predicts each pixel's result transfers and compares them in order.
// Depends on tgem_pkg for widths and register indexes.
module tgem_checker import tgem_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_pix_valid,
    input  logic                  i_pix_stall,
    input  logic [PIX_W-1:0]      i_pixel_value,
    input  logic                  i_res_valid,
    input  logic                  i_res_stall,
    input  logic                  i_edge_bit,
    input  logic [OUT_W-1:0]      i_out_row,
    input  logic [OUT_W-1:0]      i_out_col,
    input  logic                  i_last_in_run,
    input  logic                  i_frame_done,
    output int                    o_mismatches,
    output int                    o_pending
);

    typedef struct packed {
        logic             edge_bit;
        logic [OUT_W-1:0] row;
        logic [OUT_W-1:0] col;
        logic             last_in_run;
        logic             frame_done;
    } t_edge_result;

    t_edge_result      expected_bits[$];
    logic [PIX_W-1:0]  row_above [MAX_WIDTH];
    logic [PIX_W-1:0]  left_pix;
    int unsigned       row_pos;
    int unsigned       col_pos;
    logic [PIX_W-1:0]  threshold;
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    int                mismatches = 0;

    function automatic int unsigned clamp_size(input logic [SIZE_W-1:0] v,
                                               input int unsigned limit);
        if (v == 0) return 1;
        if (v > limit) return limit;
        return v;
    endfunction

    function automatic logic gradient_over(input logic [PIX_W-1:0] a,
                                           input logic [PIX_W-1:0] b);
        logic [PIX_W-1:0] diff;
        diff = (a > b) ? a - b : b - a;
        return diff > threshold;
    endfunction

    function automatic t_edge_result make_result(input logic flat, input int unsigned row,
                                                 input int unsigned col, input logic done);
        t_edge_result res;
        res.edge_bit    = flat;
        res.row         = row[OUT_W-1:0];
        res.col         = col[OUT_W-1:0];
        res.last_in_run = 1'b0;
        res.frame_done  = done;
        return res;
    endfunction

    task automatic predict_bits(input logic [PIX_W-1:0] pix);
        int unsigned  w;
        int unsigned  h;
        int unsigned  r;
        int unsigned  c;
        logic         last_col;
        logic         last_row;
        logic         flat;
        logic [PIX_W-1:0] above;
        t_edge_result batch [3];
        int           n;
        int           k;
        w = clamp_size(width_reg, MAX_WIDTH);
        h = clamp_size(height_reg, MAX_HEIGHT);
        r = row_pos;
        c = col_pos;
        last_col = (c + 1 >= w);
        last_row = (r + 1 >= h);
        n = 0;
        if (c >= MAX_WIDTH) c = MAX_WIDTH - 1;

        // release the pixel above: it tests the pixel below and its right neighbor
        if (r > 0) begin
            above = row_above[c];
            flat = 1'b1;
            if (gradient_over(above, pix)) flat = 1'b0;
            if (!last_col && c + 1 < MAX_WIDTH && gradient_over(above, row_above[c+1]))
                flat = 1'b0;
            batch[n] = make_result(flat, r - 1, c, 1'b0);
            n++;
        end
        if (last_row) begin
            if (c > 0) begin
                batch[n] = make_result(!gradient_over(left_pix, pix), r, c - 1, 1'b0);
                n++;
            end
            // the frame's final pixel has no neighbors
            if (last_col) begin
                batch[n] = make_result(1'b1, r, c, 1'b1);
                n++;
            end
        end

        row_above[c] = pix;
        left_pix = pix;
        if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end

        if (n > 0) batch[n-1].last_in_run = 1'b1;
        for (k = 0; k < n; k++) expected_bits.push_back(batch[k]);
    endtask

    task automatic check_result();
        t_edge_result got;
        t_edge_result want;
        got.edge_bit    = i_edge_bit;
        got.row         = i_out_row;
        got.col         = i_out_col;
        got.last_in_run = i_last_in_run;
        got.frame_done  = i_frame_done;
        if (expected_bits.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: bit=%0b row=%0d col=%0d last=%0b done=%0b",
                         got.edge_bit, got.row, got.col, got.last_in_run, got.frame_done);
        end else begin
            want = expected_bits.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result mismatch: expected bit=%0b row=%0d col=%0d last=%0b ",
                              "done=%0b, got bit=%0b row=%0d col=%0d last=%0b done=%0b"},
                             want.edge_bit, want.row, want.col, want.last_in_run,
                             want.frame_done, got.edge_bit, got.row, got.col,
                             got.last_in_run, got.frame_done);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_bits.delete();
            left_pix   = '0;
            row_pos    = 0;
            col_pos    = 0;
            threshold  = '0;
            width_reg  = SIZE_W'(MAX_WIDTH);
            height_reg = SIZE_W'(MAX_HEIGHT);
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_THRESHOLD:    threshold  = i_cfg_data[PIX_W-1:0];
                    CFG_FRAME_WIDTH:  width_reg  = i_cfg_data;
                    CFG_FRAME_HEIGHT: height_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_pix_valid && !i_pix_stall) predict_bits(i_pixel_value);
            if (i_res_valid && !i_res_stall) check_result();
        end
        o_pending    <= expected_bits.size();
        o_mismatches <= mismatches;
    end

endmodule

// ----- bench/tb_threshold_gradient_edge_map.sv -----
// Top of the edge map testbench: clock, reset, register writes, pixel stimulus and
// result-side stalls; the verdict comes from the failure count of tgem_checker.
// Depends on tgem_pkg, tgem_checker and threshold_gradient_edge_map.
module tb_threshold_gradient_edge_map;
    import tgem_pkg::*;

    // index past the last register; writes to it must have no effect
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_THRESHOLD;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic [PIX_W-1:0]      i_pixel_value = '0;
    logic                  i_stall = 1'b0;
    logic                  o_stall;
    logic                  o_valid;
    logic                  o_edge_bit;
    logic [OUT_W-1:0]      o_out_row;
    logic [OUT_W-1:0]      o_out_col;
    logic                  o_last_in_run;
    logic                  o_frame_done;

    int                    mismatches;
    int                    pending;
    logic                  calm = 1'b0;
    logic [PIX_W-1:0]      last_pix = '0;
    logic [PIX_W-1:0]      thr_now = '0;
    int                    pixels_sent = 0;
    int                    random_start;

    threshold_gradient_edge_map dut (.*);

    tgem_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_pix_valid   (i_valid),
        .i_pix_stall   (o_stall),
        .i_pixel_value (i_pixel_value),
        .i_res_valid   (o_valid),
        .i_res_stall   (i_stall),
        .i_edge_bit    (o_edge_bit),
        .i_out_row     (o_out_row),
        .i_out_col     (o_out_col),
        .i_last_in_run (o_last_in_run),
        .i_frame_done  (o_frame_done),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_pixel_value <= pix;
        last_pix = pix;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pixels_sent++;
    endtask

    // mostly values on either side of the threshold from the previous pixel
    function automatic logic [PIX_W-1:0] shaped_pixel();
        case ($urandom_range(0, 3))
            0: return PIX_W'($urandom_range(0, 255));
            1: return last_pix;
            2: return last_pix + thr_now;
            default: return last_pix - thr_now - 1'b1;
        endcase
    endfunction

    task automatic send_pixels(input int count);
        repeat (count) send_pixel(shaped_pixel());
    endtask

    // Drain all results, give the block time to settle, then write every register.
    task automatic apply_config(input logic [CFG_DATA_W-1:0] thr,
                                input logic [CFG_DATA_W-1:0] wid,
                                input logic [CFG_DATA_W-1:0] hgt);
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_THRESHOLD;
        i_cfg_data  <= thr;
        @(posedge i_clk);
        i_cfg_index <= CFG_FRAME_WIDTH;
        i_cfg_data  <= wid;
        @(posedge i_clk);
        i_cfg_index <= CFG_FRAME_HEIGHT;
        i_cfg_data  <= hgt;
        @(posedge i_clk);
        i_cfg_index <= CFG_UNUSED;
        i_cfg_data  <= CFG_DATA_W'($urandom_range(0, 2047));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        thr_now = thr[PIX_W-1:0];
    endtask

    // result side: stall a random number of cycles, none when calm, before each transfer
    initial begin : result_sink
        int gap;
        @(posedge i_clk);
        forever begin
            gap = calm ? 0 : $urandom_range(0, 4);
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin : stimulus
        logic [CFG_DATA_W-1:0] thr;
        logic [CFG_DATA_W-1:0] wid;
        logic [CFG_DATA_W-1:0] hgt;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero threshold against full-scale steps
        apply_config(11'd0, 11'd3, 11'd2);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd255);
        send_pixel(8'd0);
        send_pixel(8'd0);
        send_pixel(8'd255);
        // top threshold: nothing is an edge
        apply_config(11'd255, 11'd2, 11'd2);
        send_pixel(8'd255);
        send_pixel(8'd0);
        send_pixel(8'd0);
        send_pixel(8'd255);
        // zero width acts as one column; differences at and just past the threshold
        apply_config(11'd100, 11'd0, 11'd3);
        send_pixel(8'd0);
        send_pixel(8'd100);
        send_pixel(8'd201);
        // zero height gives a single-row frame; upper data bits of the threshold drop
        apply_config(11'h707, 11'd4, 11'd0);
        send_pixel(8'd10);
        send_pixel(8'd18);
        send_pixel(8'd17);
        send_pixel(8'd9);
        // shrink width and height mid-frame so the next pixel ends the frame
        apply_config(11'd30, 11'd4, 11'd3);
        send_pixels(6);
        apply_config(11'd30, 11'd2, 11'd1);
        send_pixels(1);

        // oversize width saturates; this row fills the line buffer columns that
        // later rows read, then a long column runs down a full-height frame
        apply_config(11'd60, 11'd2047, 11'd1);
        send_pixels(64);
        calm = 1'b1;
        apply_config(11'd20, 11'd1, 11'd1024);
        send_pixels(40);

        // random segments: small widths, heights now and then saturated, so that
        // new settings often land mid-frame
        random_start = pixels_sent;
        while (pixels_sent < random_start + 80) begin
            calm = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
                0: thr = 11'd0;
                1: thr = 11'd255;
                default: thr = CFG_DATA_W'($urandom_range(0, 2047));
            endcase
            wid = CFG_DATA_W'($urandom_range(0, 6));
            hgt = ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom_range(1024, 2047))
                                              : CFG_DATA_W'($urandom_range(0, 5));
            apply_config(thr, wid, hgt);
            send_pixels($urandom_range(1, 24));
        end

        i_valid <= 1'b0;
        calm = 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- threshold_gradient_edge_map.f -----
rtl/core/tgem_pkg.sv
rtl/core/tgem_cell.sv
rtl/core/tgem_line_buf.sv
rtl/core/threshold_gradient_edge_map.sv
bench/tgem_checker.sv
bench/tb_threshold_gradient_edge_map.sv
